FILE: src/fbcf_pkg.sv
`default_nettype none

package fbcf_pkg;

    // Block index width and the number of addressable blocks
    localparam int BLK_W   = 5;
    localparam int BLK_CNT = 1 << BLK_W;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_SET_EDGE   = 2'd0,
        REQ_MARK_FAIL  = 2'd1,
        REQ_CLEAR_FAIL = 2'd2,
        REQ_QUERY      = 2'd3
    } t_req_type;

    // Input transfer payload
    typedef struct packed {
        t_req_type          req_type;
        logic [BLK_W-1:0]   first_block;
        logic [BLK_W-1:0]   second_block;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [BLK_W-1:0]   member_block;
        logic               last_member;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch accepted request, apply mask updates
        logic wr_edge;   // write back adjacency row with new edge bit
        logic rd_scan;   // read row of lowest pending member, mark it visited
        logic merge;     // fold read row into the member mask
        logic emit;      // move lowest member into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pend_any;  // members still to expand
        logic out_free;  // output register can take a member
        logic rem_last;  // one member left to emit
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: src/failed_block_cluster_finder_unit.sv
`default_nettype none

// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_ready     | i_in_item  (fbcf_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready   | o_out_item (fbcf_pkg::t_out_item)
//
// Set edge reads the source row and writes it back with the new edge bit;
// mark failed and clear failures complete on acceptance. A query expands each
// member of the cluster with one read and one merge of its row, then emits the members.
// The adjacency memory is single port with registered read.
// Reset clears failures and row valid bits at once; no clearing pass.
// A stalled output holds the emit phase; one item is in work at a time.
module failed_block_cluster_finder_unit #(
    parameter int NUM_BLOCKS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  fbcf_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fbcf_pkg::t_out_item    o_out_item
);

    fbcf_pkg::t_dp_cmd cmd;
    fbcf_pkg::t_dp_sts sts;

    fbcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fbcf_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: src/fbcf_ctrl.sv
`default_nettype none

module fbcf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  fbcf_pkg::t_req_type    i_req_type,
    input  fbcf_pkg::t_dp_sts      i_sts,
    output logic                   o_in_ready,
    output fbcf_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_SCAN,
        S_MERGE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_req_type)
                        fbcf_pkg::REQ_SET_EDGE: n_state = S_EDGE_RD;
                        fbcf_pkg::REQ_QUERY:    n_state = S_SCAN;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            // row read of the edge source is in flight
            S_EDGE_RD: begin
                n_state = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                o_cmd.wr_edge = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.pend_any) begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_MERGE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_SCAN;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.rem_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/fbcf_datapath.sv
`default_nettype none

module fbcf_datapath #(
    parameter int NUM_BLOCKS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  fbcf_pkg::t_in_item     i_in_item,
    input  fbcf_pkg::t_dp_cmd      i_cmd,
    input  wire logic              i_out_ready,
    output fbcf_pkg::t_dp_sts      o_sts,
    output logic                   o_out_valid,
    output fbcf_pkg::t_out_item    o_out_item
);

    localparam int BLK_W  = fbcf_pkg::BLK_W;
    localparam int BLK_N  = fbcf_pkg::BLK_CNT;
    // rows actually stored: indices at or above NUM_BLOCKS never get edges
    localparam int ROWS   = (NUM_BLOCKS < BLK_N) ? NUM_BLOCKS : BLK_N;
    localparam int ROW_AW = $clog2(ROWS);
    localparam logic [BLK_N-1:0] VALID_MASK = (NUM_BLOCKS >= BLK_N) ? {BLK_N{1'b1}} :
                                              ((BLK_N'(1) << NUM_BLOCKS) - BLK_N'(1));

    // Lowest set bit of a block mask
    function automatic logic [BLK_W-1:0] f_lowest(input logic [BLK_N-1:0] v);
        logic [BLK_W-1:0] idx;
        idx = '0;
        for (int i = BLK_N - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BLK_W'(i);
            end
        end
        return idx;
    endfunction

    logic [BLK_N-1:0]  r_adj_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [BLK_N-1:0]  r_rdata;
    logic              r_rd_vld;
    logic [BLK_N-1:0]  r_failed;
    logic [BLK_N-1:0]  r_members;
    logic [BLK_N-1:0]  r_visited;
    logic [BLK_W-1:0]  r_first;
    logic [BLK_W-1:0]  r_second;
    logic              r_out_vld;
    fbcf_pkg::t_out_item r_out_item;

    logic [BLK_N-1:0]  pending;
    logic [BLK_W-1:0]  pend_idx;
    logic [BLK_W-1:0]  emit_idx;
    logic [ROW_AW-1:0] raddr;
    logic [BLK_N-1:0]  row_eff;
    logic              in_first_ok;
    logic              edge_ok;
    logic              rem_last;

    assign pending     = r_members & ~r_visited;
    assign pend_idx    = f_lowest(pending);
    assign emit_idx    = f_lowest(r_members);
    assign raddr       = i_cmd.rd_scan ? pend_idx[ROW_AW-1:0] : r_first[ROW_AW-1:0];
    assign row_eff     = r_rd_vld ? r_rdata : '0;
    assign in_first_ok = VALID_MASK[i_in_item.first_block];
    assign edge_ok     = VALID_MASK[r_first] && VALID_MASK[r_second];
    assign rem_last    = ((r_members & (r_members - BLK_N'(1))) == '0);

    assign o_sts.pend_any = (pending != '0);
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_sts.rem_last = rem_last;
    assign o_out_valid    = r_out_vld;
    assign o_out_item     = r_out_item;

    // Adjacency rows: single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_edge && edge_ok) begin
            r_adj_mem[r_first[ROW_AW-1:0]] <= row_eff | (BLK_N'(1) << r_second);
        end
        r_rdata <= r_adj_mem[raddr];
    end

    // Row valid bits stand in for clearing the rows at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[raddr];
            if (i_cmd.wr_edge && edge_ok) begin
                r_row_vld[r_first[ROW_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Request latch and failure mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= '0;
        end else if (i_cmd.load) begin
            case (i_in_item.req_type)
                fbcf_pkg::REQ_MARK_FAIL: begin
                    if (in_first_ok) begin
                        r_failed[i_in_item.first_block] <= 1'b1;
                    end
                end
                fbcf_pkg::REQ_CLEAR_FAIL: begin
                    r_failed <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first  <= i_in_item.first_block;
            r_second <= i_in_item.second_block;
        end
    end

    // Closure mask: expand one member per read, then drain in ascending order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_members <= '0;
            r_visited <= '0;
        end else if (i_cmd.load) begin
            r_members <= BLK_N'(1) << i_in_item.first_block;
            // a block out of range is returned alone, with no expansion
            r_visited <= in_first_ok ? '0 : (BLK_N'(1) << i_in_item.first_block);
        end else if (i_cmd.rd_scan) begin
            r_visited[pend_idx] <= 1'b1;
        end else if (i_cmd.merge) begin
            r_members <= r_members | (row_eff & r_failed & VALID_MASK);
        end else if (i_cmd.emit) begin
            r_members[emit_idx] <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.member_block <= emit_idx;
            r_out_item.last_member  <= rem_last;
        end
    end

`ifndef SYNTH
    // expansion only reads rows of members not yet expanded
    a_scan_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_scan |-> (pending != '0))
        else $error("row read issued with no pending member");

    // merging never loses a member
    a_merge_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |=> (($past(r_members) & ~r_members) == '0))
        else $error("member dropped during merge");

    // each emitted member removes exactly one bit
    a_emit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> ($countones(r_members) + 1 == $countones($past(r_members))))
        else $error("emit did not clear exactly one member");

    // last flag goes out only with the final member
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && rem_last) |=> (r_members == '0) && o_out_item.last_member)
        else $error("last member flagged with members left");
`endif

endmodule

`default_nettype wire
